FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the permutation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while the block is out of reset.
`define KPG_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/kpg_pkg.sv
// Package with the shared types and codes of the k-permutation generator.
`timescale 1ns / 1ps
`default_nettype none
package kpg_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_N  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_M = 2'd1;

    localparam logic KIND_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_LD_FIN,
        S_NEXT,
        S_POP,
        S_SCAN,
        S_FILL,
        S_CMP_RD,
        S_CMP_CHK,
        S_EM_RD,
        S_EM_WAIT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/k_permutation_generator.sv
// Top level of the lexicographic k-permutation generator.
// Usage:
//   The input channel (i_in_valid / o_in_ready) takes one item per transfer.
//   A load item (kind 0) inserts its value into an ascending sorted store and
//   gives no result; a full store drops the value. Larger entries are read
//   from the top down and each shifts up one place.
//   An advance item (kind 1) produces the next arrangement, one result per
//   element, position 0 first, with last_element on the final one. The search
//   scans and fills the positions, compares the elements against the previous
//   arrangement, and reads each emitted element through the store RAM's
//   registered read port. When nothing remains, one result with done_res.
//   The configuration channel (i_cfg_valid / o_cfg_ready) is always ready;
//   index 0 writes count_n, index 1 writes length_m, other indexes are
//   ignored. A write to either register, or any load, restarts the enumeration.
//   Results sit in an output register; a stalled receiver holds it, and the
//   sequencer waits only when it has another result to place. The next input
//   item is taken while the last result still waits.
//   Reset (synchronous, active low) clears the sequencer, the loaded count
//   and the enumeration state; the store RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module k_permutation_generator #(
    parameter int MAX_ITEMS  = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_kind,
    input  wire logic [VALUE_BITS-1:0]          i_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [VALUE_BITS-1:0]          o_element_value,
    output logic      [2:0]                     o_position,
    output logic                                o_last_element,
    output logic                                o_done_res,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [kpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kpg_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import kpg_pkg::*;

    // CW holds counts up to MAX_ITEMS; PW addresses one store entry.
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

    t_state r_state, n_state;
    logic [CFG_DAT_W-1:0] r_cnt_n, n_cnt_n, r_len_m, n_len_m;
    logic [CW-1:0] r_loaded, n_loaded;
    logic [PW-1:0] r_stack [MAX_ITEMS];
    logic [PW-1:0] n_stack [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_mask, n_mask;
    logic r_started, n_started, r_exh, n_exh, r_first, n_first;
    logic [CW-1:0] r_idx, n_idx, r_k, n_k;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic r_ov, n_ov;
    logic [VALUE_BITS-1:0] r_oval, n_oval;
    logic [2:0] r_pos, n_pos;
    logic r_olast, n_olast, r_odone, n_odone;

    logic st_rd_en, st_we, pv_rd_en, pv_we;
    logic [PW-1:0] st_rd_addr, st_wr_addr, pv_rd_addr, pv_wr_addr;
    logic [VALUE_BITS-1:0] st_rdata, st_wdata, pv_rdata, pv_wdata;

    logic [CW-1:0] n_eff, m_eff, dm1;
    logic slot_free, cfg_xfer;

    // Lowest free position below n, clamped to n-1 when all are taken.
    function automatic logic [CW-1:0] f_lowest(input logic [MAX_ITEMS-1:0] mask,
                                               input logic [CW-1:0] n);
        logic [CW-1:0] res;
        res = n - 1'b1;
        for (int j = MAX_ITEMS - 1; j >= 0; j--) begin
            if (CW'(j) < n && !mask[j]) begin
                res = CW'(j);
            end
        end
        return res;
    endfunction

    kpg_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS), .AW(PW)) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rdata),
        .i_wr_en   (st_we),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wdata)
    );

    kpg_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS), .AW(PW)) u_prev (
        .i_clk     (i_clk),
        .i_rd_en   (pv_rd_en),
        .i_rd_addr (pv_rd_addr),
        .o_rd_data (pv_rdata),
        .i_wr_en   (pv_we),
        .i_wr_addr (pv_wr_addr),
        .i_wr_data (pv_wdata)
    );

    assign n_eff = (r_cnt_n > MAX_ITEMS) ? MAXC : CW'(r_cnt_n);
    assign m_eff = CW'(r_len_m);
    assign dm1 = r_idx - 1'b1;
    assign slot_free = !r_ov || i_out_ready;
    assign cfg_xfer = i_cfg_valid;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_element_value = r_oval;
    assign o_position = r_pos;
    assign o_last_element = r_olast;
    assign o_done_res = r_odone;

    always_comb begin
        n_state = r_state;
        n_cnt_n = r_cnt_n;
        n_len_m = r_len_m;
        n_loaded = r_loaded;
        n_stack = r_stack;
        n_mask = r_mask;
        n_started = r_started;
        n_exh = r_exh;
        n_first = r_first;
        n_idx = r_idx;
        n_k = r_k;
        n_val = r_val;
        n_ov = r_ov && !i_out_ready;
        n_oval = r_oval;
        n_pos = r_pos;
        n_olast = r_olast;
        n_odone = r_odone;
        st_rd_en = 1'b0;
        st_rd_addr = r_stack[r_idx[PW-1:0]];
        st_we = 1'b0;
        st_wr_addr = r_idx[PW-1:0];
        st_wdata = r_val;
        pv_rd_en = 1'b0;
        pv_rd_addr = r_idx[PW-1:0];
        pv_we = 1'b0;
        pv_wr_addr = r_idx[PW-1:0];
        pv_wdata = st_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        for (int j = 0; j < MAX_ITEMS; j++) begin
                            n_stack[j] = '0;
                        end
                        n_mask = '0;
                        n_started = 1'b0;
                        n_exh = 1'b0;
                        n_val = i_value;
                        if (r_loaded < MAXC) begin
                            n_loaded = r_loaded + 1'b1;
                            if (r_loaded == '0) begin
                                st_we = 1'b1;
                                st_wr_addr = '0;
                                st_wdata = i_value;
                            end else begin
                                n_idx = r_loaded;
                                n_state = S_LD_RD;
                            end
                        end
                    end else if (r_len_m == '0 || r_len_m > n_eff || r_exh) begin
                        n_exh = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_LD_RD: begin
                st_rd_en = 1'b1;
                st_rd_addr = dm1[PW-1:0];
                n_state = S_LD_CMP;
            end
            S_LD_CMP: begin
                st_we = 1'b1;
                if (st_rdata > r_val) begin
                    // Shift the larger entry up one place and keep looking.
                    st_wdata = st_rdata;
                    n_idx = dm1;
                    n_state = (r_idx == CW'(1)) ? S_LD_FIN : S_LD_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LD_FIN: begin
                st_we = 1'b1;
                st_wr_addr = '0;
                n_state = S_IDLE;
            end
            S_NEXT: begin
                if (!r_started) begin
                    n_mask = '0;
                    for (int j = 0; j < MAX_ITEMS; j++) begin
                        if (CW'(j) < m_eff) begin
                            n_stack[j] = PW'(j);
                            n_mask[j] = 1'b1;
                        end
                    end
                    n_started = 1'b1;
                    n_first = 1'b1;
                    n_idx = '0;
                    n_state = S_CMP_RD;
                end else begin
                    n_first = 1'b0;
                    n_idx = m_eff;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_idx = dm1;
                n_mask[r_stack[dm1[PW-1:0]]] = 1'b0;
                n_k = CW'(r_stack[dm1[PW-1:0]]) + 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_k < n_eff && r_mask[r_k[PW-1:0]]) begin
                    n_k = r_k + 1'b1;
                end else if (r_k < n_eff) begin
                    n_stack[r_idx[PW-1:0]] = r_k[PW-1:0];
                    n_mask[r_k[PW-1:0]] = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = S_FILL;
                end else if (r_idx == '0) begin
                    n_exh = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_FILL: begin
                if (r_idx < m_eff) begin
                    n_k = f_lowest(r_mask, n_eff);
                    n_stack[r_idx[PW-1:0]] = n_k[PW-1:0];
                    n_mask[n_k[PW-1:0]] = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = '0;
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                if (r_first) begin
                    n_state = S_EM_RD;
                end else begin
                    st_rd_en = 1'b1;
                    pv_rd_en = 1'b1;
                    n_state = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (st_rdata != pv_rdata) begin
                    n_idx = '0;
                    n_state = S_EM_RD;
                end else if (r_idx + 1'b1 == m_eff) begin
                    // Same values as the arrangement before: skip it.
                    n_state = S_NEXT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_EM_RD: begin
                st_rd_en = 1'b1;
                n_state = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    n_oval = st_rdata;
                    n_pos = 3'(r_idx);
                    n_olast = (r_idx + 1'b1 == m_eff);
                    n_odone = 1'b0;
                    pv_we = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = (r_idx + 1'b1 == m_eff) ? S_IDLE : S_EM_RD;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    n_oval = '0;
                    n_pos = '0;
                    n_olast = 1'b0;
                    n_odone = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_xfer && (i_cfg_index == CFG_COUNT_N || i_cfg_index == CFG_LENGTH_M)) begin
            if (i_cfg_index == CFG_COUNT_N) begin
                n_cnt_n = i_cfg_data;
            end else begin
                n_len_m = i_cfg_data;
            end
            for (int j = 0; j < MAX_ITEMS; j++) begin
                n_stack[j] = '0;
            end
            n_mask = '0;
            n_started = 1'b0;
            n_exh = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_n <= CFG_DAT_W'(1);
            r_len_m <= CFG_DAT_W'(1);
            r_loaded <= '0;
            for (int j = 0; j < MAX_ITEMS; j++) begin
                r_stack[j] <= '0;
            end
            r_mask <= '0;
            r_started <= 1'b0;
            r_exh <= 1'b0;
            r_first <= 1'b0;
            r_idx <= '0;
            r_k <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_n <= n_cnt_n;
            r_len_m <= n_len_m;
            r_loaded <= n_loaded;
            r_stack <= n_stack;
            r_mask <= n_mask;
            r_started <= n_started;
            r_exh <= n_exh;
            r_first <= n_first;
            r_idx <= n_idx;
            r_k <= n_k;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_oval <= n_oval;
        r_pos <= n_pos;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/kpg_ram.sv
// Synchronous RAM with separate read and write ports, a registered read and one write per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/kpg_checker.sv
// Port-level checker for the k-permutation generator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kpg_checker #(
    parameter int VALUE_BITS = 16
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [VALUE_BITS-1:0] o_element_value,
    input wire logic [2:0]            o_position,
    input wire logic                  o_last_element,
    input wire logic                  o_done_res
);

    `KPG_ASSERT(a_out_hold, o_out_valid && !i_out_ready, ##1 (o_out_valid && $stable(o_element_value)), "result changed while stalled")
    `KPG_ASSERT(a_done_zero, o_out_valid && o_done_res, o_element_value == '0 && o_position == '0 && !o_last_element, "done result carries data")
    `KPG_ASSERT(a_busy_mid, o_out_valid && !o_done_res && !o_last_element, !o_in_ready, "input taken inside an arrangement")
    `KPG_ASSERT_NEXT(a_rst_clear, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind k_permutation_generator kpg_checker #(.VALUE_BITS(VALUE_BITS)) u_kpg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_element_value (o_element_value),
    .o_position      (o_position),
    .o_last_element  (o_last_element),
    .o_done_res      (o_done_res)
);
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the k-permutation generator: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
    import kpg_pkg::*;

    // The advance kind is not named in the package, so it is named here.
    localparam logic KIND_ADVANCE = 1'b1;
    // Indexes beyond the two registers; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int STORE_DEPTH = 8;
    // Loads give no result to show when they finish, so idle this long before a write.
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 410;

    typedef enum logic [1:0] {ROW_LOAD, ROW_ADV, ROW_CFG} t_row_op;

    typedef struct packed {
        logic [15:0] element_value;
        logic [2:0]  position;
        logic        last_element;
        logic        done_res;
    } t_element;

    // One directed row. For a register write, arg holds the index above the data.
    typedef struct packed {
        t_row_op     op;
        logic [15:0] arg;
        logic        typed;
        t_element    res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    logic [15:0]          i_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [15:0]          o_element_value;
    logic [2:0]           o_position;
    logic                 o_last_element;
    logic                 o_done_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    k_permutation_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_element_value (o_element_value),
        .o_position      (o_position),
        .o_last_element  (o_last_element),
        .o_done_res      (o_done_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model state of the block: the sorted store, the position stack and the mask.
    logic [15:0] store_val [STORE_DEPTH];
    logic [15:0] prev_val [STORE_DEPTH];
    int          pos_stk [STORE_DEPTH];
    logic [15:0] used;
    int          loaded;
    bit          begun;
    bit          spent;
    logic [3:0]  cnt_n;
    logic [3:0]  len_m;

    t_element arrangement_q[$];
    int       errs;
    int       cycles;
    bit       calm;
    int       rdy_wait;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // The run is cut off here if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Receiver stalls; no new ones start while a calm stretch is running.
    always @(posedge i_clk) begin
        if (rdy_wait > 0) begin
            rdy_wait <= rdy_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                rdy_wait <= pick_gap();
        end
    end

    // Results are checked at the falling edge ahead of the rising edge that transfers them, when
    // every output and the ready are settled.
    always @(negedge i_clk) begin
        t_element want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (arrangement_q.size() == 0) begin
                $error("result with no expectation waiting");
                errs++;
            end else begin
                want = arrangement_q.pop_front();
                if (o_element_value !== want.element_value) begin
                    $error("element_value: expected %0h, got %0h",
                           want.element_value, o_element_value);
                    errs++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    errs++;
                end
                if (o_last_element !== want.last_element) begin
                    $error("last_element: expected %0b, got %0b",
                           want.last_element, o_last_element);
                    errs++;
                end
                if (o_done_res !== want.done_res) begin
                    $error("done_res: expected %0b, got %0b", want.done_res, o_done_res);
                    errs++;
                end
            end
        end
    end

    function automatic void restart_walk();
        for (int d = 0; d < STORE_DEPTH; d++)
            pos_stk[d] = 0;
        used = '0;
        begun = 1'b0;
        spent = 1'b0;
    endfunction

    // Moves the position stack on to the next arrangement; 0 when none remain.
    function automatic bit step_positions(int n, int m);
        int d;
        int k;
        if (!begun) begin
            used = '0;
            for (d = 0; d < m; d++) begin
                pos_stk[d] = d;
                used[d] = 1'b1;
            end
            begun = 1'b1;
            return 1'b1;
        end
        d = m;
        while (d > 0) begin
            d--;
            used[pos_stk[d]] = 1'b0;
            k = pos_stk[d] + 1;
            while (k < n && used[k])
                k++;
            if (k < n) begin
                pos_stk[d] = k;
                used[k] = 1'b1;
                // Refill the tail with the lowest free positions.
                for (int e = d + 1; e < m; e++) begin
                    k = 0;
                    while (k < n && used[k])
                        k++;
                    if (k >= n)
                        k = n - 1;
                    pos_stk[e] = k;
                    used[k] = 1'b1;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the results of one accepted item and queues them (or, with keep clear, only updates the model).
    function automatic void predict_item(logic kind, logic [15:0] val, bit keep);
        int n;
        int m;
        int i;
        bit first;
        bit same;
        t_element r;
        if (kind == KIND_LOAD) begin
            if (loaded < STORE_DEPTH) begin
                i = loaded;
                while (i > 0 && store_val[i-1] > val) begin
                    store_val[i] = store_val[i-1];
                    i--;
                end
                store_val[i] = val;
                loaded++;
            end
            restart_walk();
            return;
        end
        n = (cnt_n > STORE_DEPTH) ? STORE_DEPTH : cnt_n;
        m = len_m;
        if (m == 0 || m > n)
            spent = 1'b1;
        while (!spent) begin
            first = !begun;
            if (!step_positions(n, m)) begin
                spent = 1'b1;
                break;
            end
            // Skip an arrangement whose values repeat the one just emitted.
            same = !first;
            for (int d = 0; d < m && same; d++)
                if (prev_val[d] != store_val[pos_stk[d]])
                    same = 1'b0;
            if (same)
                continue;
            for (int d = 0; d < m; d++) begin
                prev_val[d] = store_val[pos_stk[d]];
                r.element_value = prev_val[d];
                r.position = d[2:0];
                r.last_element = (d + 1 == m);
                r.done_res = 1'b0;
                if (keep)
                    arrangement_q.push_back(r);
            end
            return;
        end
        r = '0;
        r.done_res = 1'b1;
        if (keep)
            arrangement_q.push_back(r);
    endfunction

    // Sends one item after a random gap (none while calm) and predicts it at the edge that transfers it.
    task automatic send_item(logic kind, logic [15:0] val, bit typed, t_element res);
        int gap;
        bit acc;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_value <= val;
        do begin
            @(negedge i_clk);
            acc = o_in_ready;
            @(posedge i_clk);
        end while (!acc);
        predict_item(kind, val, !typed);
        if (typed)
            arrangement_q.push_back(res);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        wait (arrangement_q.size() == 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        bit acc;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_COUNT_N)
            cnt_n = data;
        else if (idx == CFG_LENGTH_M)
            len_m = data;
        if (idx == CFG_COUNT_N || idx == CFG_LENGTH_M)
            restart_walk();
    endtask

    // Directed rows: both value extremes, duplicate values to exercise the skip,
    // length zero and length above count, repeated advances after exhaustion,
    // and writes to indexes that do not exist.
    t_row dir_tab [] = '{
        '{ROW_LOAD, 16'hFFFF, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b1, '{16'hFFFF, 3'd0, 1'b1, 1'b0}},
        '{ROW_ADV,  16'h0000, 1'b1, '{16'h0000, 3'd0, 1'b0, 1'b1}},
        '{ROW_ADV,  16'h0000, 1'b1, '{16'h0000, 3'd0, 1'b0, 1'b1}},
        '{ROW_LOAD, 16'h0000, 1'b0, '0},
        '{ROW_LOAD, 16'h0000, 1'b0, '0},
        '{ROW_CFG,  {10'd0, CFG_COUNT_N, 4'd3}, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_CFG,  {10'd0, CFG_LENGTH_M, 4'd0}, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b1, '{16'h0000, 3'd0, 1'b0, 1'b1}},
        '{ROW_CFG,  {10'd0, CFG_LENGTH_M, 4'd15}, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b1, '{16'h0000, 3'd0, 1'b0, 1'b1}},
        '{ROW_CFG,  {10'd0, CFG_LENGTH_M, 4'd3}, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_CFG,  {10'd0, CFG_SPARE_A, 4'd5}, 1'b0, '0},
        '{ROW_CFG,  {10'd0, CFG_SPARE_B, 4'd15}, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0},
        '{ROW_ADV,  16'h0000, 1'b0, '0}
    };

    initial begin
        int sent;
        int n_hi;
        int pick_n;
        int pick_m;
        int advs;
        logic [15:0] v;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COUNT_N;
        i_cfg_data = '0;
        i_out_ready = 1'b0;
        errs = 0;
        cycles = 0;
        calm = 1'b0;
        rdy_wait = 0;
        loaded = 0;
        cnt_n = 4'd1;
        len_m = 4'd1;
        for (int d = 0; d < STORE_DEPTH; d++) begin
            store_val[d] = '0;
            prev_val[d] = '0;
        end
        restart_walk();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].op == ROW_CFG)
                write_reg(dir_tab[r].arg[5:4], dir_tab[r].arg[3:0]);
            else
                send_item((dir_tab[r].op == ROW_ADV) ? KIND_ADVANCE : KIND_LOAD,
                          dir_tab[r].arg, dir_tab[r].typed, dir_tab[r].res);
        end

        // Random phases: new settings, then mostly advances with the odd load mixed in.
        // count_n passes what was loaded only once the store is full, so no unwritten entry is read.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (loaded < STORE_DEPTH && $urandom_range(0, 1) == 0) begin
                v = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
                send_item(KIND_LOAD, v, 1'b0, '0);
                sent++;
            end
            n_hi = (loaded == STORE_DEPTH) ? 15 : loaded;
            // Small counts keep the walks short; full and saturated counts now and then.
            pick_n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_hi)
                                                 : $urandom_range(1, (n_hi < 4) ? n_hi : 4);
            if ($urandom_range(0, 9) == 0)
                pick_m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(pick_n, 15);
            else
                pick_m = $urandom_range(1, (pick_n > STORE_DEPTH) ? STORE_DEPTH : pick_n);
            if ($urandom_range(0, 19) == 0)
                write_reg(CFG_SPARE_B, 4'($urandom));
            write_reg(CFG_COUNT_N, 4'(pick_n));
            write_reg(CFG_LENGTH_M, 4'(pick_m));
            advs = $urandom_range(1, 25);
            for (int a = 0; a < advs && sent < RANDOM_ITEMS; a++) begin
                if ($urandom_range(0, 14) == 0)
                    send_item(KIND_LOAD, 16'($urandom), 1'b0, '0);
                else
                    send_item(KIND_ADVANCE, 16'($urandom), 1'b0, '0);
                sent++;
                // Hold the sender once until everything has drained.
                if (sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
        end

        i_in_valid <= 1'b0;
        wait (arrangement_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errs == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/kpg_pkg.sv
hw/rtl/kpg_ram.sv
hw/rtl/k_permutation_generator.sv
hw/rtl/kpg_checker.sv
test/tb.sv
